// ===== rtl/core/tpsd_pkg.sv =====
// Shared types and constants for the TGA pixel stream decoder.
// No dependencies; every other file of the decoder imports this package.
`timescale 1ns / 1ps

package tpsd_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPRESSED      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_TOTAL     = 2'd2;
   localparam int unsigned CSR_DATA_W = 32;

   // Reset values of the configuration registers
   localparam logic [2:0]  BPP_RESET        = 3'd4;
   localparam logic        COMPRESSED_RESET = 1'b1;
   localparam logic [31:0] PIXEL_TOTAL_RESET = 32'd1;

   // Narrow source pixels carry B,G,R only
   localparam logic [2:0] BPP_NARROW = 3'd3;
   localparam logic [1:0] FINAL_POS_WIDE   = 2'd3;
   localparam logic [1:0] FINAL_POS_NARROW = 2'd2;

   // Default depth of the queue between front and back
   localparam int unsigned TPSD_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [2:0]  bytes_per_pixel;
      logic        compressed;
      logic [31:0] pixel_total;
   } cfg_type;

   // One classified pixel run on its way from front to back
   typedef struct packed {
      logic       wide;
      logic [7:0] held0;
      logic [7:0] held1;
      logic [7:0] held2;
      logic [7:0] last_byte;
      logic [7:0] run_length;
      logic       last_of_image;
   } run_rec_type;

endpackage

// ===== rtl/core/tpsd_front.sv =====
// Front end: packet parsing, pixel byte gathering and run clamping.
// Depends on tpsd_pkg; pushes one run record per completed pixel.
`timescale 1ns / 1ps

module tpsd_front
   import tpsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   input  logic [7:0]  in_byte,
   input  logic        queue_full,
   output logic        in_ready,
   output logic        push,
   output run_rec_type push_rec
);

   logic [31:0] pixels_done_ff, pixels_done_in;
   logic        expect_pkt_ff, expect_pkt_in;
   logic        pkt_repeat_ff, pkt_repeat_in;
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic [1:0]  byte_pos_ff, byte_pos_in;
   logic [7:0]  held_ff [3];

   logic        accept;
   logic        wide;
   logic [1:0]  final_pos;
   logic        pkt_byte;
   logic        gather;
   logic        emit;
   logic [7:0]  left;
   logic [7:0]  left_dec;
   logic [7:0]  want;
   logic        total_gt;
   logic [31:0] remaining;
   logic [7:0]  run;
   logic        last;

   assign in_ready  = !queue_full;
   assign accept    = in_valid && in_ready;
   assign wide      = (cfg.bytes_per_pixel != BPP_NARROW);
   assign final_pos = wide ? FINAL_POS_WIDE : FINAL_POS_NARROW;
   assign pkt_byte  = cfg.compressed && expect_pkt_ff;
   assign gather    = !pkt_byte && (byte_pos_ff < final_pos);
   assign emit      = !pkt_byte && !gather;

   // An empty packet count behaves as one pixel left
   assign left     = (pkt_left_ff == 8'd0) ? 8'd1 : pkt_left_ff;
   assign left_dec = left - 8'd1;

   always_comb begin
      if (!cfg.compressed) begin
         want = 8'd1;
      end else if (pkt_repeat_ff) begin
         want = left;
      end else begin
         want = 8'd1;
      end
   end

   // Clamp to the pixels that remain; an exhausted total ends the image at once
   assign total_gt  = cfg.pixel_total > pixels_done_ff;
   assign remaining = cfg.pixel_total - pixels_done_ff;

   always_comb begin
      if (!total_gt) begin
         run  = 8'd1;
         last = 1'b1;
      end else if ({24'd0, want} >= remaining) begin
         run  = remaining[7:0];
         last = 1'b1;
      end else begin
         run  = want;
         last = 1'b0;
      end
   end

   always_comb begin
      pixels_done_in = pixels_done_ff;
      expect_pkt_in  = expect_pkt_ff;
      pkt_repeat_in  = pkt_repeat_ff;
      pkt_left_in    = pkt_left_ff;
      byte_pos_in    = byte_pos_ff;
      if (accept) begin
         if (pkt_byte) begin
            pkt_repeat_in = in_byte[7];
            pkt_left_in   = {1'b0, in_byte[6:0]} + 8'd1;
            expect_pkt_in = 1'b0;
            byte_pos_in   = 2'd0;
         end else if (gather) begin
            byte_pos_in = byte_pos_ff + 2'd1;
         end else begin
            if (cfg.compressed) begin
               if (pkt_repeat_ff) begin
                  pkt_left_in   = 8'd0;
                  expect_pkt_in = 1'b1;
               end else begin
                  pkt_left_in   = left_dec;
                  expect_pkt_in = (left_dec == 8'd0);
               end
            end
            if (last) begin
               // drop the rest of an open packet and restart
               pixels_done_in = 32'd0;
               expect_pkt_in  = 1'b1;
               pkt_left_in    = 8'd0;
               pkt_repeat_in  = 1'b0;
            end else begin
               pixels_done_in = pixels_done_ff + {24'd0, run};
            end
            byte_pos_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_done_ff <= 32'd0;
         expect_pkt_ff  <= 1'b1;
         pkt_repeat_ff  <= 1'b0;
         pkt_left_ff    <= 8'd0;
         byte_pos_ff    <= 2'd0;
      end else begin
         pixels_done_ff <= pixels_done_in;
         expect_pkt_ff  <= expect_pkt_in;
         pkt_repeat_ff  <= pkt_repeat_in;
         pkt_left_ff    <= pkt_left_in;
         byte_pos_ff    <= byte_pos_in;
      end
   end

   // Gathered bytes are payload only
   always_ff @(posedge clock) begin
      if (accept && gather) begin
         case (byte_pos_ff)
            2'd0:    held_ff[0] <= in_byte;
            2'd1:    held_ff[1] <= in_byte;
            2'd2:    held_ff[2] <= in_byte;
            default: held_ff[2] <= held_ff[2];
         endcase
      end
   end

   assign push                   = accept && emit;
   assign push_rec.wide          = wide;
   assign push_rec.held0         = held_ff[0];
   assign push_rec.held1         = held_ff[1];
   assign push_rec.held2         = held_ff[2];
   assign push_rec.last_byte     = in_byte;
   assign push_rec.run_length    = run;
   assign push_rec.last_of_image = last;

   a_restart_after_last : assert property (@(posedge clock) disable iff (reset)
      push && push_rec.last_of_image |=> pixels_done_ff == 32'd0 && expect_pkt_ff)
      else $error("decoder did not restart after the last run of an image");

   a_run_nonzero : assert property (@(posedge clock) disable iff (reset)
      push |-> push_rec.run_length != 8'd0)
      else $error("run of zero pixels pushed");

endmodule

// ===== rtl/core/tpsd_queue.sv =====
// Short run-record queue between the front and back ends.
// Depends on tpsd_pkg for the run record type.
`timescale 1ns / 1ps

module tpsd_queue
   import tpsd_pkg::*;
#(
   parameter int unsigned DEPTH = TPSD_QUEUE_DEPTH
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr,
   input  run_rec_type wr_rec,
   input  logic        rd,
   output run_rec_type rd_rec,
   output logic        full,
   output logic        empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   run_rec_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full   = (count_ff == CNT_FULL);
   assign empty  = (count_ff == '0);
   assign rd_rec = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr && !rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd && !wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= wr_rec;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      wr |-> !full)
      else $error("write into full queue");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      rd |-> !empty)
      else $error("read from empty queue");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

endmodule

// ===== rtl/core/tpsd_back.sv =====
// Back end: channel reorder to R,G,B,A and the result output register.
// Depends on tpsd_pkg for the run record type.
`timescale 1ns / 1ps

module tpsd_back
   import tpsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_empty,
   input  run_rec_type head_rec,
   output logic        pop,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [39:0] out_data,
   output logic        out_last
);

   logic        valid_ff, valid_in;
   logic [39:0] data_ff, data_in;
   logic        last_ff, last_in;
   logic [7:0]  red, green, blue, alpha;

   // Wide pixels: B,G,R,A; narrow pixels: B,G,R with the final byte as red
   assign red   = head_rec.wide ? head_rec.held2 : head_rec.last_byte;
   assign green = head_rec.held1;
   assign blue  = head_rec.held0;
   assign alpha = head_rec.wide ? head_rec.last_byte : 8'd0;

   assign pop      = !queue_empty && (!valid_ff || out_ready);
   assign valid_in = pop || (valid_ff && !out_ready);
   assign data_in  = pop ? {head_rec.run_length, alpha, blue, green, red} : data_ff;
   assign last_in  = pop ? head_rec.last_of_image : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_last  = last_ff;

endmodule

// ===== rtl/core/tga_pixel_stream_decoder_unit.sv =====
// Top level of the TGA pixel stream decoder: configuration registers and
// the front end, run queue and back end. Depends on tpsd_pkg and the tpsd_ modules.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  req_tdata: data_byte
// rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata: red,green,blue,alpha,run_length;
//                                             rsp_tlast: last_of_image
// csr_      in         csr_we (no wait)       csr_index, csr_wdata
//
// One image byte is taken per cycle while the run queue is not full. The byte that
// completes a pixel writes its run into the queue at its own transfer edge; the back
// end then loads that run into the output register once the register is free, and
// rsp_tvalid is driven from that register.
// Throughput is set by the front end, which updates its counters once per byte.
// reset is synchronous and active high; it restores register defaults and
// empties the queue and output register.
// A stalled rsp_ side fills the run queue; req_tready drops only when it is full.

module tga_pixel_stream_decoder_unit
   import tpsd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = TPSD_QUEUE_DEPTH
)(
   input  logic                   clock,
   input  logic                   reset,
   // image byte transfers
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   // pixel run transfers
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                               // [31:24] alpha, [39:32] run_length
   output logic                   rsp_tlast,   // last_of_image
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic        queue_full;
   logic        queue_empty;
   logic        push;
   logic        pop;
   run_rec_type push_rec;
   run_rec_type head_rec;

   // Hold configuration; each write lands in the indexed register, others drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_wdata[2:0];
            CSR_COMPRESSED:      cfg_in.compressed      = csr_wdata[0];
            CSR_PIXEL_TOTAL:     cfg_in.pixel_total     = csr_wdata[31:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel <= BPP_RESET;
         cfg_ff.compressed      <= COMPRESSED_RESET;
         cfg_ff.pixel_total     <= PIXEL_TOTAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify each byte, advance packet and pixel counters
   tpsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .queue_full (queue_full),
      .in_ready   (req_tready),
      .push       (push),
      .push_rec   (push_rec)
   );

   // Decouple the two ends so either may stall
   tpsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr     (push),
      .wr_rec (push_rec),
      .rd     (pop),
      .rd_rec (head_rec),
      .full   (queue_full),
      .empty  (queue_empty)
   );

   // Back end: reorder channels and drive the result register
   tpsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_rec    (head_rec),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule
